>>> rtl/bba_pkg.sv
package bba_pkg;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    // Width of an internal order value, wide enough for any segment order
    localparam int ORD_W = 5;

    // Smallest segment order the register accepts
    localparam logic [ORD_W-1:0] SEG_ORDER_FLOOR = 5'd15;
    localparam logic [ORD_W-1:0] SEG_ORDER_RESET = 5'd18;

    typedef struct packed {
        logic        opcode;
        logic [12:0] request_size;
        logic [17:0] block_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] granted_offset;
        logic [3:0]  granted_order;
    } out_item_t;

endpackage

>>> rtl/bba_ram.sv
module bba_ram #(
    parameter int AW = 12,
    parameter int DW = 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata_reg
);

    logic [DW-1:0] mem [2**AW];

    // Single port: write when enabled, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

>>> rtl/bba_node_unit.sv
module bba_node_unit #(
    parameter int MAX_SEGMENT_LOG2 = 18,
    parameter int MIN_BLOCK_LOG2   = 7
) (
    input  logic [4:0]                                order,
    input  logic [MAX_SEGMENT_LOG2:0]                 offset,
    output logic [MAX_SEGMENT_LOG2-MIN_BLOCK_LOG2:0]  node
);
    import bba_pkg::*;

    localparam int OFFW = MAX_SEGMENT_LOG2 + 1;
    localparam int NW   = MAX_SEGMENT_LOG2 - MIN_BLOCK_LOG2 + 1;

    logic [OFFW-1:0] base;
    logic [OFFW-1:0] sum;

    // Tree node of the block at this order and offset: level base plus index
    always_comb begin
        base = (OFFW'(1) << (ORD_W'(MAX_SEGMENT_LOG2) - order)) - OFFW'(1);
        sum  = base + (offset >> order);
        node = sum[NW-1:0];
    end

endmodule

>>> rtl/buddy_block_allocator.sv
// Buddy allocator over a power-of-two segment (2^segment_order bytes). Each
// request is an allocate (128..4096 bytes, rounded up to a power of two) or a
// free of an allocated block's offset, and each gives one result. The free
// map (one bit per tree node) and the order table (one entry per minimum
// block) sit in single-port memories, and one node-index unit addresses every
// free-map access of a request. An allocate probes free-map nodes one at a
// time from the wanted order upward in address order, then writes each split
// level, records the grant in the order table and loads the result. A free
// reads and clears the block's order table entry, absorbs free buddies order
// by order, marks the merged block free and loads the result. A bad size or
// bad offset goes straight to the result step. A result held by m_ready low
// stalls the block. After reset and after each segment_order write, a
// clearing pass over every free-map and order-table entry runs, then the
// whole segment is marked free; during this no request is taken.
module buddy_block_allocator #(
    parameter int MAX_SEGMENT_LOG2 = 18,
    parameter int MIN_BLOCK_LOG2   = 7,
    parameter int MAX_BLOCK_LOG2   = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  bba_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bba_pkg::out_item_t m_data
);
    import bba_pkg::*;

    localparam int OFFW = MAX_SEGMENT_LOG2 + 1;
    localparam int NW   = MAX_SEGMENT_LOG2 - MIN_BLOCK_LOG2 + 1;
    localparam int TW   = MAX_SEGMENT_LOG2 - MIN_BLOCK_LOG2;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_IDLE  = 11'b00000000100,
        S_PRD   = 11'b00000001000,
        S_PCHK  = 11'b00000010000,
        S_SPLIT = 11'b00000100000,
        S_FCHK  = 11'b00001000000,
        S_MRD   = 11'b00010000000,
        S_MCHK  = 11'b00100000000,
        S_MSET  = 11'b01000000000,
        S_RESP  = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic [ORD_W-1:0] seg_reg, seg_next;
    logic [ORD_W-1:0] k_reg, k_next;
    logic [ORD_W-1:0] j_reg, j_next;
    logic [ORD_W-1:0] want_reg, want_next;
    logic [OFFW-1:0]  off_reg, off_next;
    logic [1:0]       rst_reg, rst_next;
    logic [OFFW-1:0]  roff_reg, roff_next;
    logic [ORD_W-1:0] rord_reg, rord_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic [ORD_W-1:0] nu_order;
    logic [OFFW-1:0]  nu_off;
    logic [NW-1:0]    nu_node;

    logic             fm_we, fm_wd, fm_rdata;
    logic [NW-1:0]    fm_addr;
    logic             tb_we;
    logic [TW-1:0]    tb_addr;
    logic [ORD_W-1:0] tb_wd, tb_rdata;

    logic [ORD_W-1:0] want_c;
    logic             size_bad;
    logic             off_bad;
    logic [OFFW-1:0]  seg_size;
    logic [OFFW-1:0]  next_off;
    logic [ORD_W-1:0] cfg_sat;

    bba_node_unit #(
        .MAX_SEGMENT_LOG2 (MAX_SEGMENT_LOG2),
        .MIN_BLOCK_LOG2   (MIN_BLOCK_LOG2)
    ) u_node (
        .order  (nu_order),
        .offset (nu_off),
        .node   (nu_node)
    );

    bba_ram #(.AW(NW), .DW(1)) u_free_map (
        .aclk      (aclk),
        .we        (fm_we),
        .addr      (fm_addr),
        .wdata     (fm_wd),
        .rdata_reg (fm_rdata)
    );

    bba_ram #(.AW(TW), .DW(ORD_W)) u_order_table (
        .aclk      (aclk),
        .we        (tb_we),
        .addr      (tb_addr),
        .wdata     (tb_wd),
        .rdata_reg (tb_rdata)
    );

    // Decode the incoming request (rounded order, size and offset checks), the probe step and the clamped segment order
    always_comb begin
        want_c = ORD_W'(MAX_BLOCK_LOG2);
        for (int w = MAX_BLOCK_LOG2; w >= MIN_BLOCK_LOG2; w--) begin
            if (17'(s_data.request_size) <= (17'(1) << w)) begin
                want_c = ORD_W'(w);
            end
        end
        size_bad = (17'(s_data.request_size) < (17'(1) << MIN_BLOCK_LOG2)) ||
                   (17'(s_data.request_size) > (17'(1) << MAX_BLOCK_LOG2));
        off_bad  = (32'(s_data.block_offset) >= (32'(1) << seg_reg)) ||
                   (s_data.block_offset[MIN_BLOCK_LOG2-1:0] != '0);
        seg_size = OFFW'(1) << seg_reg;
        next_off = off_reg + (OFFW'(1) << k_reg);
        if (cfg_wr_data < SEG_ORDER_FLOOR) begin
            cfg_sat = SEG_ORDER_FLOOR;
        end else if (cfg_wr_data > ORD_W'(MAX_SEGMENT_LOG2)) begin
            cfg_sat = ORD_W'(MAX_SEGMENT_LOG2);
        end else begin
            cfg_sat = cfg_wr_data;
        end
    end

    // Pick operands for the shared node-index unit
    always_comb begin
        nu_order = k_reg;
        nu_off   = off_reg;
        unique case (state_reg)
            S_INIT: begin
                nu_order = seg_reg;
                nu_off   = '0;
            end
            S_SPLIT: begin
                nu_order = j_reg - ORD_W'(1);
                nu_off   = off_reg + (OFFW'(1) << (j_reg - ORD_W'(1)));
            end
            S_MRD, S_MCHK: begin
                nu_off = off_reg ^ (OFFW'(1) << k_reg);
            end
            default: begin
                nu_order = k_reg;
                nu_off   = off_reg;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        seg_next     = seg_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        want_next    = want_reg;
        off_next     = off_reg;
        rst_next     = rst_reg;
        roff_next    = roff_reg;
        rord_next    = rord_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        fm_addr = nu_node;
        fm_we   = 1'b0;
        fm_wd   = 1'b0;
        tb_addr = off_reg[MIN_BLOCK_LOG2 +: TW];
        tb_we   = 1'b0;
        tb_wd   = '0;
        s_ready = (state_reg == S_IDLE);

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                fm_addr  = cnt_reg;
                fm_we    = 1'b1;
                tb_addr  = cnt_reg[TW-1:0];
                tb_we    = 1'b1;
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == {NW{1'b1}}) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                fm_we      = 1'b1;
                fm_wd      = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                tb_addr = TW'(s_data.block_offset >> MIN_BLOCK_LOG2);
                if (s_valid) begin
                    off_next  = OFFW'(s_data.block_offset);
                    want_next = want_c;
                    rst_next  = ST_OK;
                    roff_next = '0;
                    rord_next = '0;
                    if (s_data.opcode == OP_ALLOC) begin
                        if (size_bad) begin
                            rst_next   = ST_BAD_SIZE;
                            state_next = S_RESP;
                        end else begin
                            k_next     = want_c;
                            off_next   = '0;
                            state_next = S_PRD;
                        end
                    end else if (off_bad) begin
                        rst_next   = ST_NOT_ALLOC;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_FCHK;
                    end
                end
            end
            S_PRD: begin
                if (k_reg > seg_reg) begin
                    rst_next   = ST_NO_SPACE;
                    state_next = S_RESP;
                end else begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK: begin
                if (fm_rdata) begin
                    // Take the block and split it down
                    fm_we      = 1'b1;
                    j_next     = k_reg;
                    state_next = S_SPLIT;
                end else if (next_off >= seg_size) begin
                    k_next     = k_reg + ORD_W'(1);
                    off_next   = '0;
                    state_next = S_PRD;
                end else begin
                    off_next   = next_off;
                    state_next = S_PRD;
                end
            end
            S_SPLIT: begin
                if (j_reg > want_reg) begin
                    fm_we  = 1'b1;
                    fm_wd  = 1'b1;
                    j_next = j_reg - ORD_W'(1);
                end else begin
                    tb_we      = 1'b1;
                    tb_wd      = want_reg;
                    roff_next  = off_reg;
                    rord_next  = want_reg;
                    state_next = S_RESP;
                end
            end
            S_FCHK: begin
                if (tb_rdata == '0) begin
                    rst_next   = ST_NOT_ALLOC;
                    state_next = S_RESP;
                end else begin
                    tb_we      = 1'b1;
                    roff_next  = off_reg;
                    rord_next  = tb_rdata;
                    k_next     = tb_rdata;
                    state_next = S_MRD;
                end
            end
            S_MRD: begin
                if (k_reg < seg_reg) begin
                    state_next = S_MCHK;
                end else begin
                    state_next = S_MSET;
                end
            end
            S_MCHK: begin
                if (fm_rdata) begin
                    // Absorb the free buddy and climb one order
                    fm_we      = 1'b1;
                    off_next   = off_reg & ~(OFFW'(1) << k_reg);
                    k_next     = k_reg + ORD_W'(1);
                    state_next = S_MRD;
                end else begin
                    state_next = S_MSET;
                end
            end
            S_MSET: begin
                fm_we      = 1'b1;
                fm_wd      = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.status          = rst_reg;
                    m_data_next.granted_offset  = 18'(roff_reg);
                    m_data_next.granted_order   = 4'(rord_reg);
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase

        // Segment write restarts the clearing pass
        if (cfg_wr_en) begin
            seg_next   = cfg_sat;
            cnt_next   = '0;
            state_next = S_CLR;
        end
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            cnt_reg     <= '0;
            seg_reg     <= (SEG_ORDER_RESET > ORD_W'(MAX_SEGMENT_LOG2)) ?
                           ORD_W'(MAX_SEGMENT_LOG2) : SEG_ORDER_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            seg_reg     <= seg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload and working values
    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        j_reg      <= j_next;
        want_reg   <= want_next;
        off_reg    <= off_next;
        rst_reg    <= rst_next;
        roff_reg   <= roff_next;
        rord_reg   <= rord_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
